### hw/rtl/udprc_pkg.sv
// ----------------------------------------------------------------------------
// udprc_pkg
// Shared constants and types for the reassembly context table.
// ----------------------------------------------------------------------------
package udprc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int PARTS_W     = 17;
    localparam int SIZE_W      = 32;
    localparam int PSIZE_W     = 16;
    localparam int MC_W        = 5;

    localparam logic [PARTS_W-1:0] PARTS_MAX = '1;

    localparam logic [15:0] UDP_MAX_BYTES  = 16'd65535;
    localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [15:0] PART_HDR_BYTES = 16'd16;
    localparam logic [PSIZE_W-1:0] PART_SIZE_RST =
        UDP_MAX_BYTES - (IP_HDR_BYTES + UDP_HDR_BYTES + PART_HDR_BYTES);
    localparam logic [MC_W-1:0] MAX_CONTEXTS_RST = MC_W'(MAX_ENTRIES);

    // register indexes
    localparam logic REG_MAX_CONTEXTS = 1'b0;
    localparam logic REG_PART_SIZE    = 1'b1;

    // request types
    localparam logic REQ_PART    = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STS_STORED  = 2'd0;
    localparam logic [1:0] STS_DONE    = 2'd1;
    localparam logic [1:0] STS_REL     = 2'd2;
    localparam logic [1:0] STS_REL_BAD = 2'd3;

    typedef struct packed {
        logic [SIZE_W-1:0]  ident;
        logic [SIZE_W-1:0]  total;
        logic [PARTS_W-1:0] parts;
        logic [IDX_W-1:0]   slot;
    } entry_t;

    typedef struct packed {
        logic shift;   // take the neighbor's entry
        logic load;    // take a new entry
        logic dec;     // count one part
    } cell_ctrl_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   done_index;
        logic [SIZE_W-1:0]  done_size;
        logic [IDX_W-1:0]   write_slot;
        logic [SIZE_W-1:0]  write_offset;
        logic [15:0]        write_length;
        logic               evicted;
        logic [SIZE_W-1:0]  evicted_ident;
        logic [PARTS_W-1:0] evicted_missing;
        logic               replaced_corrupt;
    } result_t;

endpackage

### hw/rtl/udp_reassembly_context_table.sv
// ----------------------------------------------------------------------------
// udp_reassembly_context_table
// Age-ordered table of reassembly contexts for fragmented messages.
// ----------------------------------------------------------------------------
// Input channel s_*: one item is a part header (s_req_type 0) or a release
// of a list position (s_req_type 1). Result channel m_*: exactly one result
// item per input item, in order. Config channel cfg_*: register 0 is
// max_contexts, register 1 is part_size; always ready, write only when idle.
// One item is worked on at a time; s_ready is high only when idle.
// A release or a hit goes through the lookup and output states before m_valid.
// A new context goes through lookup, eviction, the bit-serial divider that
// splits total_size into parts, the append and the output.
// The contexts live in a row of 16 cells; removal shifts the upper cells
// down by one, all at the same clock edge.
// Reset clears the context count, buffer slot flags and the result valid
// flag, and loads the register defaults (16 contexts, part size 65491).
// If the receiver stalls, the result waits in the output register; one more
// item can be taken and worked on, and its result waits until that is free.
// ----------------------------------------------------------------------------
module udp_reassembly_context_table
    import udprc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_req_type,
    input  logic [31:0]         s_msg_ident,
    input  logic [31:0]         s_total_size,
    input  logic [31:0]         s_part_offset,
    input  logic [15:0]         s_part_length,
    input  logic [3:0]          s_release_index,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [3:0]          m_done_index,
    output logic [31:0]         m_msg_size_out,
    output logic [3:0]          m_write_slot,
    output logic [31:0]         m_write_offset,
    output logic [15:0]         m_write_length,
    output logic                m_evicted,
    output logic [31:0]         m_evicted_ident,
    output logic [16:0]         m_evicted_missing,
    output logic                m_replaced_corrupt
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_EVICT, ST_DIV, ST_APPEND, ST_OUT
    } state_t;

    state_t state_reg;

    logic [MC_W-1:0]    max_ctx_reg;
    logic [PSIZE_W-1:0] part_size_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [MAX_ENTRIES-1:0] busy_reg;

    logic               req_reg;
    logic [31:0]        ident_reg;
    logic [31:0]        total_reg;
    logic [31:0]        offset_reg;
    logic [15:0]        length_reg;
    logic [IDX_W-1:0]   rel_reg;

    result_t res_reg;
    result_t out_reg;
    logic    m_valid_reg;

    entry_t     cell_q   [MAX_ENTRIES];
    entry_t     cell_nb  [MAX_ENTRIES];
    cell_ctrl_t cell_ctl [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_match;
    entry_t     wr_entry;

    logic               rm_en, ld_en, dec_en;
    logic [IDX_W-1:0]   rm_pos, dec_pos, ld_pos;
    logic               hit;
    logic [IDX_W-1:0]   hit_pos;
    logic [IDX_W-1:0]   free_slot;
    logic [CNT_W-1:0]   limit;
    logic               div_start, div_done;
    logic [SIZE_W-1:0]  div_q;
    logic [PSIZE_W-1:0] divisor;
    logic [PARTS_W-1:0] new_parts;
    logic [PARTS_W-1:0] dec_parts;
    logic               rel_ok;
    logic               total_eq;

    // lookup: lowest matching live position
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (cell_match[i] && (CNT_W'(i) < count_reg)) begin
                hit     = 1'b1;
                hit_pos = IDX_W'(i);
            end
        end
    end

    always_comb begin
        free_slot = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_slot = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (max_ctx_reg == '0) begin
            limit = CNT_W'(1);
        end else if (max_ctx_reg > MC_W'(MAX_ENTRIES)) begin
            limit = CNT_W'(MAX_ENTRIES);
        end else begin
            limit = CNT_W'(max_ctx_reg);
        end
    end

    assign divisor   = (part_size_reg == '0) ? PSIZE_W'(1) : part_size_reg;
    assign new_parts = (div_q[SIZE_W-1:PARTS_W] != '0) ? PARTS_MAX : div_q[PARTS_W-1:0];
    assign dec_parts = cell_q[hit_pos].parts - PARTS_W'(1);
    assign rel_ok    = ({1'b0, rel_reg} < count_reg);
    assign total_eq  = (cell_q[hit_pos].total == total_reg);
    assign ld_pos    = count_reg[IDX_W-1:0];

    // cell control for the current step
    always_comb begin
        rm_en     = 1'b0;
        rm_pos    = '0;
        ld_en     = 1'b0;
        dec_en    = 1'b0;
        dec_pos   = hit_pos;
        div_start = 1'b0;
        case (state_reg)
            ST_LOOK: begin
                if (req_reg == REQ_RELEASE) begin
                    rm_en  = rel_ok;
                    rm_pos = rel_reg;
                end else if (hit && total_eq) begin
                    dec_en = 1'b1;
                end else if (hit) begin
                    rm_en  = 1'b1;
                    rm_pos = hit_pos;
                end
            end
            ST_EVICT: begin
                rm_en     = (count_reg >= limit) && (count_reg != '0);
                div_start = 1'b1;
            end
            ST_APPEND: begin
                ld_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        wr_entry.ident = ident_reg;
        wr_entry.total = total_reg;
        wr_entry.parts = new_parts;
        wr_entry.slot  = free_slot;
    end

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        if (g == MAX_ENTRIES - 1) begin : g_top
            assign cell_nb[g] = cell_q[g];
        end else begin : g_mid
            assign cell_nb[g] = cell_q[g+1];
        end
        assign cell_ctl[g] = '{shift: rm_en && (IDX_W'(g) >= rm_pos),
                               load:  ld_en && (IDX_W'(g) == ld_pos),
                               dec:   dec_en && (IDX_W'(g) == dec_pos)};

        udprc_cell u_cell (
            .aclk    (aclk),
            .ctrl    (cell_ctl[g]),
            .nb_in   (cell_nb[g]),
            .wr_data (wr_entry),
            .key     (ident_reg),
            .q       (cell_q[g]),
            .match   (cell_match[g])
        );
    end

    udprc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_reg),
        .divisor  (divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_ctx_reg   <= MAX_CONTEXTS_RST;
            part_size_reg <= PART_SIZE_RST;
            count_reg     <= '0;
            busy_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == REG_MAX_CONTEXTS) begin
                    max_ctx_reg <= cfg_data[MC_W-1:0];
                end else begin
                    part_size_reg <= cfg_data;
                end
            end
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        req_reg    <= s_req_type;
                        ident_reg  <= s_msg_ident;
                        total_reg  <= s_total_size;
                        offset_reg <= s_part_offset;
                        length_reg <= s_part_length;
                        rel_reg    <= s_release_index;
                        res_reg    <= '0;
                        state_reg  <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (req_reg == REQ_RELEASE) begin
                        if (rel_ok) begin
                            res_reg.status     <= STS_REL;
                            res_reg.write_slot <= cell_q[rel_reg].slot;
                            busy_reg[cell_q[rel_reg].slot] <= 1'b0;
                            count_reg <= count_reg - CNT_W'(1);
                        end else begin
                            res_reg.status <= STS_REL_BAD;
                        end
                        state_reg <= ST_OUT;
                    end else if (hit && total_eq) begin
                        res_reg.write_slot   <= cell_q[hit_pos].slot;
                        res_reg.write_offset <= offset_reg;
                        res_reg.write_length <= length_reg;
                        if (dec_parts == '0) begin
                            res_reg.status     <= STS_DONE;
                            res_reg.done_index <= hit_pos;
                            res_reg.done_size  <= cell_q[hit_pos].total;
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        if (hit) begin
                            // same ident, other size: drop before rebuilding
                            res_reg.replaced_corrupt <= 1'b1;
                            busy_reg[cell_q[hit_pos].slot] <= 1'b0;
                            count_reg <= count_reg - CNT_W'(1);
                        end
                        state_reg <= ST_EVICT;
                    end
                end
                ST_EVICT: begin
                    if (rm_en) begin
                        res_reg.evicted         <= 1'b1;
                        res_reg.evicted_ident   <= cell_q[0].ident;
                        res_reg.evicted_missing <= cell_q[0].parts;
                        busy_reg[cell_q[0].slot] <= 1'b0;
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    busy_reg[free_slot]  <= 1'b1;
                    count_reg            <= count_reg + CNT_W'(1);
                    res_reg.write_slot   <= free_slot;
                    res_reg.write_offset <= offset_reg;
                    res_reg.write_length <= length_reg;
                    if (new_parts == '0) begin
                        res_reg.status     <= STS_DONE;
                        res_reg.done_index <= ld_pos;
                        res_reg.done_size  <= total_reg;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg     <= res_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready          = 1'b1;
    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = m_valid_reg;
    assign m_status           = out_reg.status;
    assign m_done_index       = out_reg.done_index;
    assign m_msg_size_out     = out_reg.done_size;
    assign m_write_slot       = out_reg.write_slot;
    assign m_write_offset     = out_reg.write_offset;
    assign m_write_length     = out_reg.write_length;
    assign m_evicted          = out_reg.evicted;
    assign m_evicted_ident    = out_reg.evicted_ident;
    assign m_evicted_missing  = out_reg.evicted_missing;
    assign m_replaced_corrupt = out_reg.replaced_corrupt;

endmodule

### hw/rtl/udprc_cell.sv
// ----------------------------------------------------------------------------
// udprc_cell
// One context of the age-ordered list; shifts down from its upper neighbor.
// ----------------------------------------------------------------------------
module udprc_cell
    import udprc_pkg::*;
(
    input  logic        aclk,
    input  cell_ctrl_t  ctrl,
    input  entry_t      nb_in,
    input  entry_t      wr_data,
    input  logic [SIZE_W-1:0] key,
    output entry_t      q,
    output logic        match
);

    entry_t e_reg;
    entry_t e_next;

    always_comb begin
        e_next = e_reg;
        if (ctrl.load) begin
            e_next = wr_data;
        end else if (ctrl.shift) begin
            e_next = nb_in;
        end else if (ctrl.dec) begin
            e_next.parts = e_reg.parts - PARTS_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        e_reg <= e_next;
    end

    assign q     = e_reg;
    assign match = (e_reg.ident == key);

endmodule

### hw/rtl/udprc_div.sv
// ----------------------------------------------------------------------------
// udprc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module udprc_div
    import udprc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SIZE_W-1:0]  dividend,
    input  logic [PSIZE_W-1:0] divisor,
    output logic [SIZE_W-1:0]  quotient,
    output logic               done
);

    localparam int STEP_W = $clog2(SIZE_W);

    logic [SIZE_W-1:0]  q_reg,   q_next;
    logic [PSIZE_W:0]   rem_reg, rem_next;
    logic [PSIZE_W-1:0] dvs_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [PSIZE_W:0]   trial;

    always_comb begin
        trial    = {rem_reg[PSIZE_W-1:0], q_reg[SIZE_W-1]};
        q_next   = {q_reg[SIZE_W-2:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, dvs_reg}) begin
            rem_next  = trial - {1'b0, dvs_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                q_reg   <= q_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(SIZE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

### hw/rtl/udprc_checker.sv
// ----------------------------------------------------------------------------
// udprc_assert
// Port-level checks of the context table, bound to the top level.
// ----------------------------------------------------------------------------
module udprc_assert
    import udprc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [3:0]  m_write_slot,
    input logic        m_evicted,
    input logic        m_replaced_corrupt
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready
            |=> $stable({m_status, m_write_slot, m_evicted, m_replaced_corrupt}))
        else $error("result changed while stalled");

    a_release_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STS_REL || m_status == STS_REL_BAD)
            |-> !m_evicted && !m_replaced_corrupt)
        else $error("release reported an eviction");

    a_bad_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STS_REL_BAD |-> m_write_slot == '0)
        else $error("invalid release reported a slot");

endmodule

bind udp_reassembly_context_table udprc_assert u_udprc_assert (.*);

### verif/udprc_checker.sv
// ----------------------------------------------------------------------------
// udprc_checker
// Watches the cfg, part and result channels of the reassembly context table,
// predicts each result from its own copy of the context list and compares.
// ----------------------------------------------------------------------------
module udprc_checker
    import udprc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_req_type,
    input  logic [31:0] s_msg_ident,
    input  logic [31:0] s_total_size,
    input  logic [31:0] s_part_offset,
    input  logic [15:0] s_part_length,
    input  logic [3:0]  s_release_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [3:0]  m_done_index,
    input  logic [31:0] m_msg_size_out,
    input  logic [3:0]  m_write_slot,
    input  logic [31:0] m_write_offset,
    input  logic [15:0] m_write_length,
    input  logic        m_evicted,
    input  logic [31:0] m_evicted_ident,
    input  logic [16:0] m_evicted_missing,
    input  logic        m_replaced_corrupt,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    entry_t          ctx_list[MAX_ENTRIES];
    int              ctx_count;
    logic            slot_used[MAX_ENTRIES];
    logic [MC_W-1:0] max_ctx;
    logic [15:0]     part_bytes;
    result_t         result_q[$];

    assign pending = result_q.size();

    function automatic logic [3:0] remove_ctx(int pos);
        logic [3:0] s;
        s = ctx_list[pos].slot;
        slot_used[s] = 1'b0;
        for (int k = pos; k + 1 < ctx_count; k++) ctx_list[k] = ctx_list[k + 1];
        ctx_count--;
        return s;
    endfunction

    function automatic result_t table_result(logic req, logic [31:0] id, logic [31:0] tot,
                                             logic [31:0] off, logic [15:0] len,
                                             logic [3:0] rel);
        result_t r;
        int      pos;
        int      lim;
        bit      hit;
        logic [31:0] ps;
        logic [31:0] parts;
        logic [3:0]  slot;
        r = '0;
        hit = 0;
        pos = 0;
        if (req == REQ_RELEASE) begin
            if (rel < ctx_count) begin
                r.status = STS_REL;
                r.write_slot = remove_ctx(rel);
            end else begin
                r.status = STS_REL_BAD;
            end
            return r;
        end
        for (int i = 0; i < ctx_count; i++) begin
            if (ctx_list[i].ident == id) begin
                hit = 1;
                pos = i;
                break;
            end
        end
        if (hit && ctx_list[pos].total != tot) begin
            void'(remove_ctx(pos));
            r.replaced_corrupt = 1'b1;
            hit = 0;
        end
        if (hit) begin
            ctx_list[pos].parts = ctx_list[pos].parts - 1'b1;
            if (ctx_list[pos].parts == '0) begin
                r.status = STS_DONE;
                r.done_index = pos[3:0];
                r.done_size = ctx_list[pos].total;
            end
            r.write_slot = ctx_list[pos].slot;
        end else begin
            lim = max_ctx;
            if (lim < 1) lim = 1;
            if (lim > MAX_ENTRIES) lim = MAX_ENTRIES;
            if (ctx_count >= lim && ctx_count > 0) begin
                r.evicted = 1'b1;
                r.evicted_ident = ctx_list[0].ident;
                r.evicted_missing = ctx_list[0].parts;
                void'(remove_ctx(0));
            end
            slot = '0;
            for (int i = MAX_ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) slot = i[3:0];
            ps = (part_bytes == 0) ? 32'd1 : {16'd0, part_bytes};
            parts = tot / ps;
            if (parts > PARTS_MAX) parts = PARTS_MAX;
            pos = ctx_count;
            ctx_list[pos] = '{ident: id, total: tot, parts: parts[16:0], slot: slot};
            slot_used[slot] = 1'b1;
            ctx_count++;
            if (parts == 0) begin
                r.status = STS_DONE;
                r.done_index = pos[3:0];
                r.done_size = tot;
            end
            r.write_slot = slot;
        end
        r.write_offset = off;
        r.write_length = len;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        result_t e;
        if (!aresetn) begin
            ctx_count = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            max_ctx = MAX_CONTEXTS_RST;
            part_bytes = PART_SIZE_RST;
            result_q.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MAX_CONTEXTS) max_ctx = cfg_data[MC_W-1:0];
                else part_bytes = cfg_data;
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    e = result_q.pop_front();
                    check_field("status", e.status, m_status);
                    check_field("done_index", e.done_index, m_done_index);
                    check_field("msg_size_out", e.done_size, m_msg_size_out);
                    check_field("write_slot", e.write_slot, m_write_slot);
                    check_field("write_offset", e.write_offset, m_write_offset);
                    check_field("write_length", e.write_length, m_write_length);
                    check_field("evicted", e.evicted, m_evicted);
                    check_field("evicted_ident", e.evicted_ident, m_evicted_ident);
                    check_field("evicted_missing", e.evicted_missing, m_evicted_missing);
                    check_field("replaced_corrupt", e.replaced_corrupt, m_replaced_corrupt);
                end
            end
            if (s_valid && s_ready)
                result_q.push_back(table_result(s_req_type, s_msg_ident, s_total_size,
                                                s_part_offset, s_part_length,
                                                s_release_index));
        end
    end
endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives part headers, releases and register writes into the reassembly
// context table; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import udprc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_MAX_CONTEXTS;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_req_type = REQ_PART;
    logic [31:0] s_msg_ident = '0;
    logic [31:0] s_total_size = '0;
    logic [31:0] s_part_offset = '0;
    logic [15:0] s_part_length = '0;
    logic [3:0]  s_release_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [3:0]  m_done_index;
    logic [31:0] m_msg_size_out;
    logic [3:0]  m_write_slot;
    logic [31:0] m_write_offset;
    logic [15:0] m_write_length;
    logic        m_evicted;
    logic [31:0] m_evicted_ident;
    logic [16:0] m_evicted_missing;
    logic        m_replaced_corrupt;
    int          fail_count;
    int          pending;
    logic [31:0] live_ids[$];
    logic [31:0] live_sizes[$];
    bit          rx_idle_off = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    udp_reassembly_context_table i_dut (.*);

    udprc_checker i_checker (.*);

    // receiver: random stall per item, with no-stall stretches
    initial begin
        int w;
        @(posedge aclk iff aresetn);
        forever begin
            w = rx_idle_off ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    // valid stays up when the next item follows at once
    task automatic send_item(logic req, logic [31:0] id, logic [31:0] tot,
                             logic [31:0] off, logic [15:0] len, logic [3:0] rel);
        int w;
        s_valid <= 1'b1;
        s_req_type <= req;
        s_msg_ident <= id;
        s_total_size <= tot;
        s_part_offset <= off;
        s_part_length <= len;
        s_release_index <= rel;
        @(posedge aclk iff s_ready);
        w = rx_idle_off ? 0 : $urandom_range(0, 12);
        if (w > 0) begin
            s_valid <= 1'b0;
            repeat (w) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk iff pending == 0);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk iff cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random part: mostly parts of known messages so contexts complete
    task automatic random_item(int tot_max);
        logic [31:0] id;
        logic [31:0] tot;
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            send_item(REQ_RELEASE, $urandom, $urandom, $urandom, 16'($urandom),
                      4'($urandom_range(0, 15)));
        end else if (r < 65 && live_ids.size() > 0) begin
            k = $urandom_range(0, live_ids.size() - 1);
            tot = live_sizes[k];
            if ($urandom_range(0, 19) == 0) tot = tot ^ (32'd1 << $urandom_range(0, 31));
            send_item(REQ_PART, live_ids[k], tot, $urandom, 16'($urandom), 4'($urandom));
        end else begin
            id = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40);
            tot = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, tot_max);
            live_ids.push_back(id);
            live_sizes.push_back(tot);
            if (live_ids.size() > 24) begin
                void'(live_ids.pop_front());
                void'(live_sizes.pop_front());
            end
            send_item(REQ_PART, id, tot, $urandom, 16'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: defaults, extremes, zero parts, saturation, releases
        send_item(REQ_RELEASE, '0, '0, '0, '0, 4'd0);
        send_item(REQ_PART, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 4'hF);
        send_item(REQ_PART, 32'd0, 32'd0, 32'd0, 16'd0, 4'd0);
        send_item(REQ_PART, 32'd7, 32'd65491 * 2, 32'd5, 16'd9, 4'd0);
        send_item(REQ_PART, 32'd7, 32'd65491 * 2, 32'd6, 16'd9, 4'd0);
        send_item(REQ_PART, 32'd7, 32'd65491 * 2, 32'd7, 16'd9, 4'd0);
        send_item(REQ_PART, 32'd7, 32'd65491 * 2, 32'd8, 16'd9, 4'd0);
        send_item(REQ_PART, 32'd7, 32'd3, 32'd1, 16'd1, 4'd0);
        send_item(REQ_RELEASE, '0, '0, '0, '0, 4'd15);
        send_item(REQ_RELEASE, '0, '0, '0, '0, 4'd1);
        write_reg(REG_PART_SIZE, 16'd0);
        send_item(REQ_PART, 32'd99, 32'hFFFF_FFFF, 32'd0, 16'd1, 4'd0);
        send_item(REQ_PART, 32'd98, 32'd5, 32'd0, 16'd1, 4'd0);
        write_reg(REG_MAX_CONTEXTS, 16'd0);
        send_item(REQ_PART, 32'd50, 32'd1, 32'd0, 16'd1, 4'd0);
        write_reg(REG_MAX_CONTEXTS, 16'd31);
        write_reg(REG_PART_SIZE, 16'hFFFF);
        for (int i = 0; i < 18; i++) send_item(REQ_PART, 32'd200 + i, 32'd70000, i, 16'd3, 4'd0);
        send_item(REQ_PART, 32'd217, 32'd1, 32'd0, 16'd0, 4'd0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MAX_CONTEXTS, 16'd1);
                    write_reg(REG_PART_SIZE, 16'd1);
                end
                1: begin
                    write_reg(REG_MAX_CONTEXTS, 16'd4);
                    write_reg(REG_PART_SIZE, 16'd100);
                end
                2: write_reg(REG_MAX_CONTEXTS, 16'd16);
                3: begin
                    write_reg(REG_MAX_CONTEXTS, 16'd3);
                    write_reg(REG_PART_SIZE, 16'd1000);
                end
                4: write_reg(REG_MAX_CONTEXTS, 16'($urandom_range(1, 31)));
                default: begin
                    write_reg(REG_MAX_CONTEXTS, 16'd8);
                    write_reg(REG_PART_SIZE, 16'd65491);
                end
            endcase
            rx_idle_off = (ph == 2);
            for (int n = 0; n < 115; n++) random_item(ph == 5 ? 300000 : 500);
        end
        rx_idle_off = 0;
        wait_drained();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end
endmodule
